// ===== src/dlr_pkg.sv =====
// Shared types, constants and helpers for the dense layer with ReLU.
package dlr_pkg;

  localparam int MAX_IN   = 16;
  localparam int MAX_OUT  = 16;
  localparam int DW       = 16;
  localparam int IN_IDX_W  = $clog2(MAX_IN);
  localparam int OUT_IDX_W = $clog2(MAX_OUT);
  localparam int WADDR_W  = OUT_IDX_W + IN_IDX_W;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W    = DW - 1;
  localparam int FRAC_W   = 8;
  // Exact sum of MAX_IN Q16.16 products plus the shifted bias
  localparam int ACC_W    = 2 * DW + IN_IDX_W + 2;

  localparam logic [CNT_W-1:0] CNT_MAX_IN  = CNT_W'(MAX_IN);
  localparam logic [CNT_W-1:0] CNT_MAX_OUT = CNT_W'(MAX_OUT);

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_COUNT  = 2'd0,
    CFG_OUT_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Tag that travels with each product through the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [ACT_W-1:0] act;
  } mac_res_t;

  // Clamp a count into 1..hi and return count-1 as an index
  function automatic logic [IN_IDX_W-1:0] cnt_last(logic [CNT_W-1:0] v,
                                                    logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] c;
    c = v;
    if (c == '0) c = CNT_W'(1);
    if (c > hi) c = hi;
    return IN_IDX_W'(c - CNT_W'(1));
  endfunction

endpackage

// ===== src/dlr_if.sv =====
// Channel interfaces: input requests, result requests and register writes.
interface dlr_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [dlr_pkg::OUT_IDX_W-1:0]       row;
  logic [dlr_pkg::IN_IDX_W-1:0]        col;
  logic signed [dlr_pkg::DW-1:0]       value;
  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface dlr_out_if;
  logic                                valid;
  logic                                ready;
  logic [dlr_pkg::OUT_IDX_W-1:0]       index;
  logic [dlr_pkg::ACT_W-1:0]           activation;
  logic                                last;
  modport source (output valid, index, activation, last, input ready);
  modport sink   (input valid, index, activation, last, output ready);
endinterface

interface dlr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dlr_pkg::CFG_IDX_W-1:0]       index;
  logic [dlr_pkg::CNT_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dlr_mac.sv =====
// Shared multiply-accumulate unit with ReLU, rounding and saturation.
module dlr_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dlr_pkg::mac_ctrl_t             ctrl_i,
  input  logic signed [dlr_pkg::DW-1:0]  weight_i,
  input  logic signed [dlr_pkg::DW-1:0]  sample_i,
  input  logic signed [dlr_pkg::DW-1:0]  bias_i,
  output dlr_pkg::mac_res_t              res_o
);

  localparam int ACC_W = dlr_pkg::ACC_W;
  localparam int DW    = dlr_pkg::DW;
  localparam int FW    = dlr_pkg::FRAC_W;
  localparam int ACT_W = dlr_pkg::ACT_W;

  dlr_pkg::mac_ctrl_t          tag_q;
  logic signed [2*DW-1:0]      prod_q;
  logic signed [DW-1:0]        bias_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d, base;
  logic                        done_q;
  logic signed [ACC_W-1:0]     rnd;
  logic [ACT_W-1:0]            act;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= weight_i * sample_i;
    bias_q <= bias_i;
  end

  // Accumulate; the first column starts from the bias in Q16.16
  always_comb begin
    base  = tag_q.first
          ? {{(ACC_W-DW-FW){bias_q[DW-1]}}, bias_q, {FW{1'b0}}}
          : acc_q;
    acc_d = base + {{(ACC_W-2*DW){prod_q[2*DW-1]}}, prod_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag_q.valid & tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.valid) acc_q <= acc_d;
  end

  // ReLU, round half up, saturate
  always_comb begin
    rnd = acc_q + ACC_W'(1 << (FW - 1));
    if (acc_q <= 0) begin
      act = '0;
    end else if ((rnd >>> FW) > ACC_W'((1 << ACT_W) - 1)) begin
      act = '1;
    end else begin
      act = rnd[FW +: ACT_W];
    end
  end

  assign res_o.done = done_q;
  assign res_o.act  = act;

endmodule

// ===== src/dense_layer_relu_core.sv =====
// Top level: fully connected layer with ReLU over loaded weight and bias tables.
// Load requests and non-final samples are accepted back to back while idle.
// The final sample of a vector starts the computation: for each of the out_count
// outputs the sequencer issues in_count columns to the shared MAC, waits in the
// drain state for the result and holds it in the output register until taken.
// Reset clears the sequencer and sets both counts to 16; tables are not cleared.
module dense_layer_relu_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  dlr_in_if.sink          in_if,
  dlr_out_if.source       out_if,
  dlr_cfg_if.sink         cfg_if
);

  localparam int DW    = dlr_pkg::DW;
  localparam int IW    = dlr_pkg::IN_IDX_W;
  localparam int OW    = dlr_pkg::OUT_IDX_W;
  localparam int CW    = dlr_pkg::CNT_W;
  localparam int ACT_W = dlr_pkg::ACT_W;

  dlr_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              in_cnt_q, out_cnt_q;
  logic [OW-1:0]              row_q, row_d;
  logic [IW-1:0]              col_q, col_d;
  logic [IW-1:0]              ni_last;
  logic [IW-1:0]              no_last;

  logic signed [DW-1:0]       w_mem [dlr_pkg::MAX_OUT * dlr_pkg::MAX_IN];
  logic signed [DW-1:0]       bias_q [dlr_pkg::MAX_OUT];
  logic signed [DW-1:0]       ibuf_q [dlr_pkg::MAX_IN];
  logic signed [DW-1:0]       w_rd_q, x_rd_q, b_rd_q;
  dlr_pkg::mac_ctrl_t         st1_q, st1_d;
  dlr_pkg::mac_res_t          mac_res;

  logic                       in_acc, cfg_acc, out_acc;
  logic                       out_valid_q;
  logic [OW-1:0]              out_index_q;
  logic [ACT_W-1:0]           out_act_q;
  logic                       out_last_q;
  dlr_pkg::kind_e             kind;

  assign kind    = dlr_pkg::kind_e'(in_if.kind);
  assign in_acc  = in_if.valid & in_if.ready;
  assign cfg_acc = cfg_if.valid & cfg_if.ready;
  assign out_acc = out_valid_q & out_if.ready;

  assign in_if.ready  = (state_q == dlr_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign ni_last = dlr_pkg::cnt_last(in_cnt_q, dlr_pkg::CNT_MAX_IN);
  assign no_last = OW'(dlr_pkg::cnt_last(out_cnt_q, dlr_pkg::CNT_MAX_OUT));

  // Count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= dlr_pkg::CNT_MAX_IN;
      out_cnt_q <= dlr_pkg::CNT_MAX_OUT;
    end else if (cfg_acc) begin
      unique case (cfg_if.index)
        dlr_pkg::CFG_IN_COUNT:  in_cnt_q  <= cfg_if.data;
        dlr_pkg::CFG_OUT_COUNT: out_cnt_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == dlr_pkg::KIND_WEIGHT) begin
      w_mem[{in_if.row, in_if.col}] <= in_if.value;
    end
    w_rd_q <= w_mem[{row_q, col_q}];
  end

  // Bias and sample registers, read at the issue address
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == dlr_pkg::KIND_BIAS) bias_q[in_if.row] <= in_if.value;
    if (in_acc && kind == dlr_pkg::KIND_SAMPLE) ibuf_q[in_if.col] <= in_if.value;
    x_rd_q <= ibuf_q[col_q];
    b_rd_q <= bias_q[row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q <= '0;
    end else begin
      st1_q <= st1_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    st1_d   = '0;
    unique case (state_q)
      dlr_pkg::ST_IDLE: begin
        row_d = '0;
        col_d = '0;
        if (in_acc && kind == dlr_pkg::KIND_SAMPLE && in_if.col == ni_last) begin
          state_d = dlr_pkg::ST_ISSUE;
        end
      end
      dlr_pkg::ST_ISSUE: begin
        st1_d.valid = 1'b1;
        st1_d.first = (col_q == '0);
        st1_d.last  = (col_q == ni_last);
        if (col_q == ni_last) begin
          col_d   = '0;
          state_d = dlr_pkg::ST_DRAIN;
        end else begin
          col_d = col_q + IW'(1);
        end
      end
      dlr_pkg::ST_DRAIN: begin
        if (mac_res.done) state_d = dlr_pkg::ST_OUT;
      end
      dlr_pkg::ST_OUT: begin
        if (out_acc) begin
          if (row_q == no_last) begin
            state_d = dlr_pkg::ST_IDLE;
          end else begin
            row_d   = row_q + OW'(1);
            state_d = dlr_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = dlr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlr_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  dlr_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (st1_q),
    .weight_i (w_rd_q),
    .sample_i (x_rd_q),
    .bias_i   (b_rd_q),
    .res_o    (mac_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == dlr_pkg::ST_DRAIN && mac_res.done) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dlr_pkg::ST_DRAIN && mac_res.done) begin
      out_index_q <= row_q;
      out_act_q   <= mac_res.act;
      out_last_q  <= (row_q == no_last);
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.index      = out_index_q;
  assign out_if.activation = out_act_q;
  assign out_if.last       = out_last_q;

endmodule
